// ===== rtl/time_varying_rate_mean_converter_macros.svh =====
// assertion macros for the rate mean converter
`ifndef TIME_VARYING_RATE_MEAN_CONVERTER_MACROS_SVH
`define TIME_VARYING_RATE_MEAN_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge
`define TVRMC_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tvrmc check failed");
// property that must hold whenever a condition holds
`define TVRMC_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvrmc implication failed");
`else
`define TVRMC_CHECK(lbl, expr)
`define TVRMC_IMPLY(lbl, ante, cons)
`endif

`endif

// ===== rtl/tvrmc_pkg.sv =====
// shared types and constants for the rate mean converter
`timescale 1ns / 1ps
package tvrmc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int HORNER_CELLS  = 14;
  localparam int DIV_CELLS     = 32;
  localparam int FIFO_DEPTH    = 128;

  localparam logic [63:0] ONE_Q30  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] LN2_Q30  = 64'd744261118;
  localparam logic [63:0] EXP_CUT  = 64'd22 << 30;

  localparam logic [1:0] FN_MEAN = 2'd0;
  localparam logic [1:0] FN_INIT = 2'd1;
  localparam logic [1:0] FN_JAC  = 2'd2;
  localparam logic [1:0] FN_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        rate_value;
    logic signed [31:0] rate_shift;
    logic [31:0]        time_to_tip;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        saturated;
  } out_item_t;

  // per-request sideband carried along the series chain
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic        kzero;
    logic        pos;
    logic        mode;   // exponential branch
    logic        big;    // e^-x flushes to zero
    logic [4:0]  m;
    logic [63:0] xs;
  } side_t;

  typedef struct packed {
    logic sat;
    logic zero;
  } dflag_t;

endpackage

// ===== rtl/time_varying_rate_mean_converter.sv =====
// top level: mean/initial rate conversion for an exponentially shifting rate
// throughput: one request per cycle while in_stall is low; 81 pipeline stages feed a 128-entry result ram
// in_stall rises only when 128 requests are accepted and not yet delivered
// reset: rst_n synchronous, clears pipeline valids, ram pointers and counts
`timescale 1ns / 1ps
`include "time_varying_rate_mean_converter_macros.svh"
module time_varying_rate_mean_converter #(
  parameter int FRAC_BITS = tvrmc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tvrmc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tvrmc_pkg::out_item_t out_data
);

  localparam int NH    = tvrmc_pkg::HORNER_CELLS;
  localparam int ND    = tvrmc_pkg::DIV_CELLS;
  localparam int NST   = 3 + 3 * NH + 4 + ND;
  localparam int XS_SH = FRAC_BITS - 6;
  localparam int DEPTH = tvrmc_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = $bits(tvrmc_pkg::out_item_t);
  localparam logic [31:0] JAC_ONE = 32'(64'd1 << FRAC_BITS);

  // ---------------- control ----------------
  logic [NST-1:0] vld_r, vld_nxt;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    cnt_r, cnt_nxt, occ_r, occ_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           in_acc, out_acc, rd_fire, wr_fire;

  assign in_stall = (occ_r == (AW+1)'(DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign wr_fire  = vld_r[NST-1];
  assign rd_fire  = (cnt_r != '0) && (!out_valid_r || !out_stall);

  always_comb begin
    vld_nxt       = {vld_r[NST-2:0], in_acc};
    wr_ptr_nxt    = wr_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt    = rd_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt       = cnt_r + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    occ_nxt       = occ_r + (AW+1)'(in_acc) - (AW+1)'(out_acc);
    out_valid_nxt = rd_fire ? 1'b1 : (out_acc ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- front: x = |k|*T, range split ----------------
  logic [1:0]  s0_func_r;
  logic [31:0] s0_value_r;
  logic        s0_kzero_r, s0_pos_r;
  logic [63:0] s0_x_r;
  logic [31:0] kmag;

  tvrmc_pkg::side_t s1_r;
  tvrmc_pkg::side_t s1_nxt;
  logic [30:0]      ge_ln2;

  logic [29:0]      s2_v_r;
  tvrmc_pkg::side_t s2_r;
  logic [34:0]      mln2;
  logic [34:0]      rr;

  always_comb begin
    kmag = in_data.rate_shift[31] ? (~in_data.rate_shift + 32'd1) : in_data.rate_shift;
  end

  always_comb begin
    s1_nxt.func  = s0_func_r;
    s1_nxt.value = s0_value_r;
    s1_nxt.kzero = s0_kzero_r;
    s1_nxt.pos   = s0_pos_r;
    s1_nxt.xs    = s0_x_r >> XS_SH;
    s1_nxt.mode  = s1_nxt.xs >= tvrmc_pkg::ONE_Q30;
    s1_nxt.big   = s1_nxt.xs >= tvrmc_pkg::EXP_CUT;
    // whole multiples of ln 2 as a thermometer code
    for (int k = 1; k <= 31; k++) begin
      ge_ln2[k-1] = s1_nxt.xs >= 64'(k) * tvrmc_pkg::LN2_Q30;
    end
    s1_nxt.m = 5'($countones(ge_ln2));
  end

  always_comb begin
    mln2 = 35'(s1_r.m) * tvrmc_pkg::LN2_Q30[34:0];
    rr   = s1_r.xs[34:0] - mln2;
  end

  always_ff @(posedge clk) begin
    s0_func_r  <= in_data.func;
    s0_value_r <= in_data.rate_value;
    s0_kzero_r <= (in_data.rate_shift == '0);
    s0_pos_r   <= !in_data.rate_shift[31];
    s0_x_r     <= 64'(kmag) * 64'(in_data.time_to_tip);
    s1_r       <= s1_nxt;
    s2_v_r     <= s1_r.mode ? rr[29:0] : s1_r.xs[29:0];
    s2_r       <= s1_r;
  end

  // ---------------- series chain ----------------
  logic [29:0]      hv [NH+1];
  logic [30:0]      ht [NH+1];
  tvrmc_pkg::side_t hs [NH+1];

  assign hv[0] = s2_v_r;
  assign ht[0] = tvrmc_pkg::ONE_Q30[30:0];
  assign hs[0] = s2_r;

  for (genvar i = 0; i < NH; i++) begin : g_horner
    tvrmc_horner_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .v_i    (hv[i]),
      .t_i    (ht[i]),
      .side_i (hs[i]),
      .v_o    (hv[i+1]),
      .t_o    (ht[i+1]),
      .side_o (hs[i+1])
    );
  end

  // ---------------- factor as num/den and operand select ----------------
  tvrmc_pkg::side_t hq;
  logic [30:0] e_val, h_val;
  logic [63:0] num, den;
  logic [31:0] op_a;
  logic [63:0] op_b, op_c;

  logic [31:0]       p_a_r;
  logic [63:0]       p_b_r, p_c_r;
  logic              p_z_r;
  logic [63:0]       m_lo_r, m_hi_r, m_c_r;
  logic              m_z_r;
  logic [95:0]       a_p_r;
  logic [63:0]       a_c_r;
  logic              a_z_r;

  logic [63:0]       drem [ND+1];
  logic [31:0]       dlo  [ND+1];
  logic [63:0]       dc   [ND+1];
  tvrmc_pkg::dflag_t dflg [ND+1];

  always_comb begin
    hq    = hs[NH];
    e_val = hq.big ? '0 : (ht[NH] >> hq.m);
    h_val = tvrmc_pkg::ONE_Q30[30:0] - e_val;
    if (hq.kzero) begin
      num = tvrmc_pkg::ONE_Q30;
      den = tvrmc_pkg::ONE_Q30;
    end else if (!hq.mode) begin
      den = tvrmc_pkg::ONE_Q30;
      num = hq.pos ? ((tvrmc_pkg::ONE_Q30 << 1) - 64'(ht[NH])) : 64'(ht[NH]);
    end else begin
      den = hq.xs;
      num = hq.pos ? ((hq.xs << 1) - 64'(h_val)) : 64'(h_val);
    end
    op_a = (hq.func == tvrmc_pkg::FN_JAC) ? JAC_ONE : hq.value;
    op_b = (hq.func == tvrmc_pkg::FN_MEAN) ? num : den;
    op_c = (hq.func == tvrmc_pkg::FN_MEAN) ? den : num;
  end

  always_ff @(posedge clk) begin
    p_a_r  <= op_a;
    p_b_r  <= op_b;
    p_c_r  <= op_c;
    p_z_r  <= (hq.func == tvrmc_pkg::FN_NONE);
    // product in two 32-bit halves
    m_lo_r <= 64'(p_a_r) * 64'(p_b_r[31:0]);
    m_hi_r <= 64'(p_a_r) * 64'(p_b_r[63:32]);
    m_c_r  <= p_c_r;
    m_z_r  <= p_z_r;
    a_p_r  <= {m_hi_r, 32'd0} + {32'd0, m_lo_r};
    a_c_r  <= m_c_r;
    a_z_r  <= m_z_r;
  end

  // quotient fits 32 bits exactly when the upper product part is below the divisor
  logic [63:0]       o_rem_r, o_c_r;
  logic [31:0]       o_lo_r;
  tvrmc_pkg::dflag_t o_flg_r;

  always_ff @(posedge clk) begin
    o_rem_r      <= a_p_r[95:32];
    o_lo_r       <= a_p_r[31:0];
    o_c_r        <= a_c_r;
    o_flg_r.sat  <= a_p_r[95:32] >= a_c_r;
    o_flg_r.zero <= a_z_r;
  end

  assign drem[0] = o_rem_r;
  assign dlo[0]  = o_lo_r;
  assign dc[0]   = o_c_r;
  assign dflg[0] = o_flg_r;

  for (genvar j = 0; j < ND; j++) begin : g_div
    tvrmc_div_cell u_cell (
      .clk   (clk),
      .rem_i (drem[j]),
      .lo_i  (dlo[j]),
      .c_i   (dc[j]),
      .flg_i (dflg[j]),
      .rem_o (drem[j+1]),
      .lo_o  (dlo[j+1]),
      .c_o   (dc[j+1]),
      .flg_o (dflg[j+1])
    );
  end

  // ---------------- result ram and output ----------------
  tvrmc_pkg::out_item_t wr_item;
  logic [OW-1:0]        rd_bits;

  always_comb begin
    if (dflg[ND].zero) begin
      wr_item.result    = '0;
      wr_item.saturated = 1'b0;
    end else if (dflg[ND].sat) begin
      wr_item.result    = '1;
      wr_item.saturated = 1'b1;
    end else begin
      wr_item.result    = dlo[ND];
      wr_item.saturated = 1'b0;
    end
  end

  tvrmc_ram #(.WIDTH(OW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_fire),
    .waddr (wr_ptr_r),
    .wdata (wr_item),
    .re    (rd_fire),
    .raddr (rd_ptr_r),
    .rdata (rd_bits)
  );

  assign out_valid = out_valid_r;
  assign out_data  = rd_bits;

  `TVRMC_CHECK(a_occ_cap, occ_r <= (AW+1)'(DEPTH))
  `TVRMC_CHECK(a_occ_cons, int'(occ_r) == $countones(vld_r) + int'(cnt_r) + int'(out_valid_r))
  `TVRMC_IMPLY(a_ram_room, wr_fire, cnt_r < (AW+1)'(DEPTH))
  `TVRMC_IMPLY(a_sat_ones, out_valid_r && out_data.saturated, out_data.result == '1)

endmodule

// ===== rtl/tvrmc_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module tvrmc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tvrmc_horner_cell.sv =====
// one horner step of the series chain: t = 1 - (v*t)/n, three register stages
`timescale 1ns / 1ps
module tvrmc_horner_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic [29:0]        v_i,
  input  logic [30:0]        t_i,
  input  tvrmc_pkg::side_t   side_i,
  output logic [29:0]        v_o,
  output logic [30:0]        t_o,
  output tvrmc_pkg::side_t   side_o
);

  // g series runs n = 15..2, exponential series n = 12..1 behind two idle cells
  localparam int          NG     = 15 - IDX;
  localparam int          NE     = (IDX < 2) ? 1 : 14 - IDX;
  localparam logic        PASS_E = (IDX < 2);
  localparam logic [32:0] RG     = 33'((64'd1 << 32) / NG);
  localparam logic [32:0] RE     = 33'((64'd1 << 32) / NE);
  localparam logic [3:0]  NG_C   = 4'(NG);
  localparam logic [3:0]  NE_C   = 4'(NE);

  logic [59:0]      pa_r;
  logic [29:0]      va_r;
  logic [30:0]      ta_r;
  tvrmc_pkg::side_t sa_r;

  logic [29:0]      ab_r;
  logic [29:0]      qb_r;
  logic [29:0]      vb_r;
  logic [30:0]      tb_r;
  tvrmc_pkg::side_t sb_r;

  logic [29:0]      vc_r;
  logic [30:0]      tc_r;
  tvrmc_pkg::side_t sc_r;

  logic [29:0] quo_a;
  logic [62:0] qprod;
  logic [3:0]  n_c;
  logic [33:0] qn;
  logic [29:0] rem_c;
  logic [29:0] q_c;
  logic [30:0] t_nxt;

  always_comb begin
    quo_a = pa_r[59:30];
    qprod = 63'(quo_a) * 63'(sa_r.mode ? RE : RG);
    n_c   = sb_r.mode ? NE_C : NG_C;
    qn    = 34'(qb_r) * 34'(n_c);
    rem_c = ab_r - qn[29:0];
    // reciprocal estimate is at most one low
    q_c   = (rem_c >= 30'(n_c)) ? qb_r + 30'd1 : qb_r;
    if (sb_r.mode && PASS_E) begin
      t_nxt = tb_r;
    end else begin
      t_nxt = tvrmc_pkg::ONE_Q30[30:0] - 31'(q_c);
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= 60'(61'(v_i) * 61'(t_i));
    va_r <= v_i;
    ta_r <= t_i;
    sa_r <= side_i;

    ab_r <= quo_a;
    qb_r <= qprod[61:32];
    vb_r <= va_r;
    tb_r <= ta_r;
    sb_r <= sa_r;

    vc_r <= vb_r;
    tc_r <= t_nxt;
    sc_r <= sb_r;
  end

  assign v_o    = vc_r;
  assign t_o    = tc_r;
  assign side_o = sc_r;

endmodule

// ===== rtl/tvrmc_div_cell.sv =====
// one restoring division step: brings down a dividend bit, shifts in a quotient bit
`timescale 1ns / 1ps
module tvrmc_div_cell (
  input  logic                clk,
  input  logic [63:0]         rem_i,
  input  logic [31:0]         lo_i,
  input  logic [63:0]         c_i,
  input  tvrmc_pkg::dflag_t   flg_i,
  output logic [63:0]         rem_o,
  output logic [31:0]         lo_o,
  output logic [63:0]         c_o,
  output tvrmc_pkg::dflag_t   flg_o
);

  logic [64:0] rem2;
  logic        ge;
  logic [64:0] diff;

  logic [63:0]       rem_r;
  logic [31:0]       lo_r;
  logic [63:0]       c_r;
  tvrmc_pkg::dflag_t flg_r;

  always_comb begin
    rem2 = {rem_i, lo_i[31]};
    ge   = rem2 >= {1'b0, c_i};
    diff = rem2 - {1'b0, c_i};
  end

  always_ff @(posedge clk) begin
    rem_r <= ge ? diff[63:0] : rem2[63:0];
    lo_r  <= {lo_i[30:0], ge};
    c_r   <= c_i;
    flg_r <= flg_i;
  end

  assign rem_o = rem_r;
  assign lo_o  = lo_r;
  assign c_o   = c_r;
  assign flg_o = flg_r;

endmodule
